FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds on every clock edge
`define CHK_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent in the same cycle as the antecedent
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Widths, payload types and cofactor selection for the 3x3 inverse core.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int ELEM_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	// cofactor: difference of two element products
	localparam int COF_W         = 2 * ELEM_W + 1;
	// determinant: sum of six triple products, with headroom
	localparam int DET_W         = 3 * ELEM_W + 3;
	// pipeline depth: 2 cofactor, 2 determinant, prep, range check,
	// one stage per quotient bit, output
	localparam int PIPE_DEPTH    = ELEM_W + 7;

	// element indexes (row * 3 + column) of x0 * x1 - y0 * y1 per adjugate entry
	localparam int unsigned COF_SEL [9][4] = '{
		'{4, 8, 7, 5},
		'{7, 2, 1, 8},
		'{1, 5, 4, 2},
		'{6, 5, 3, 8},
		'{0, 8, 6, 2},
		'{3, 2, 0, 5},
		'{3, 7, 6, 4},
		'{6, 1, 0, 7},
		'{0, 4, 3, 1}
	};

	typedef struct packed {
		logic signed [ELEM_W-1:0] a00;
		logic signed [ELEM_W-1:0] a01;
		logic signed [ELEM_W-1:0] a02;
		logic signed [ELEM_W-1:0] a10;
		logic signed [ELEM_W-1:0] a11;
		logic signed [ELEM_W-1:0] a12;
		logic signed [ELEM_W-1:0] a20;
		logic signed [ELEM_W-1:0] a21;
		logic signed [ELEM_W-1:0] a22;
	} req_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] inv00;
		logic signed [ELEM_W-1:0] inv01;
		logic signed [ELEM_W-1:0] inv02;
		logic signed [ELEM_W-1:0] inv10;
		logic signed [ELEM_W-1:0] inv11;
		logic signed [ELEM_W-1:0] inv12;
		logic signed [ELEM_W-1:0] inv20;
		logic signed [ELEM_W-1:0] inv21;
		logic signed [ELEM_W-1:0] inv22;
		logic                     singular;
		logic                     overflow;
	} rsp_t;

endpackage

FILE: sv/m3i_cof_lane.sv
// ----------------------------------------------------------------------------
// m3i_cof_lane
// One cofactor lane: x0 * x1 - y0 * y1 over two pipeline stages.
// ----------------------------------------------------------------------------
module m3i_cof_lane (
	input  logic                               clk,
	input  logic [1:0]                         en,
	input  logic signed [m3i_pkg::ELEM_W-1:0]  x0,
	input  logic signed [m3i_pkg::ELEM_W-1:0]  x1,
	input  logic signed [m3i_pkg::ELEM_W-1:0]  y0,
	input  logic signed [m3i_pkg::ELEM_W-1:0]  y1,
	output logic signed [m3i_pkg::COF_W-1:0]   cof
);
	import m3i_pkg::*;

	logic signed [2*ELEM_W-1:0] px_s1;
	logic signed [2*ELEM_W-1:0] py_s1;
	logic signed [COF_W-1:0]    cof_s2;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			px_s1 <= x0 * x1;
			py_s1 <= y0 * y1;
		end
		if (en[1]) begin
			cof_s2 <= COF_W'(px_s1) - COF_W'(py_s1);
		end
	end

	assign cof = cof_s2;

endmodule

FILE: sv/m3i_det.sv
// ----------------------------------------------------------------------------
// m3i_det
// Determinant by expansion along row 0 against the lanes' cofactors.
// Each cofactor is split in two halves to keep the multipliers narrow.
// ----------------------------------------------------------------------------
module m3i_det (
	input  logic                               clk,
	input  logic [1:0]                         en,
	input  logic signed [m3i_pkg::ELEM_W-1:0]  row0 [3],
	input  logic signed [m3i_pkg::COF_W-1:0]   cof  [3],
	output logic signed [m3i_pkg::DET_W-1:0]   det
);
	import m3i_pkg::*;

	localparam int PW = 2 * ELEM_W + 1;

	logic signed [ELEM_W:0] lo [3];
	logic signed [ELEM_W:0] hi [3];
	logic signed [PW-1:0]   plo_s3 [3];
	logic signed [PW-1:0]   phi_s3 [3];
	logic signed [DET_W-1:0] sum;
	logic signed [DET_W-1:0] det_s4;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			lo[j] = $signed({1'b0, cof[j][ELEM_W-1:0]});
			hi[j] = cof[j][COF_W-1:ELEM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= row0[j] * lo[j];
				phi_s3[j] <= row0[j] * hi[j];
			end
		end
	end

	// recombine the halves: high part weighs 2^ELEM_W
	always_comb begin
		sum = '0;
		for (int j = 0; j < 3; j++) begin
			sum = sum + (DET_W'(phi_s3[j]) <<< ELEM_W) + DET_W'(plo_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			det_s4 <= sum;
		end
	end

	assign det = det_s4;

endmodule

FILE: sv/m3i_div_lane.sv
// ----------------------------------------------------------------------------
// m3i_div_lane
// Rounded, saturating quotient cof * 2^(2F) / det, one quotient bit a stage.
// ----------------------------------------------------------------------------
module m3i_div_lane #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic [m3i_pkg::ELEM_W+2:0]         en,
	input  logic signed [m3i_pkg::COF_W-1:0]   cof,
	input  logic signed [m3i_pkg::DET_W-1:0]   det,
	output logic signed [m3i_pkg::ELEM_W-1:0]  val,
	output logic                               sat,
	output logic                               zero
);
	import m3i_pkg::*;

	localparam int NA = 2 * ELEM_W + 2 * FRAC_BITS + 1;
	localparam int NB = 3 * ELEM_W + 2;
	localparam int NW = ((NA > NB) ? NA : NB) + 1;
	localparam int RA = DET_W + ELEM_W;
	localparam int RW = ((NW > RA) ? NW : RA) + 1;

	logic [COF_W-1:0] cabs;
	logic [DET_W-1:0] dabs;

	logic [RW-1:0]    num_p;
	logic [DET_W-1:0] d2_p;
	logic             neg_p;
	logic             dz_p;

	logic [RW-1:0]     rem_s [ELEM_W+1];
	logic [DET_W-1:0]  d2_s  [ELEM_W+1];
	logic [ELEM_W-1:0] q_s   [ELEM_W+1];
	logic              neg_s [ELEM_W+1];
	logic              dz_s  [ELEM_W+1];
	logic              sat_s [ELEM_W+1];

	logic [ELEM_W-1:0] lim;
	logic              big;
	logic [ELEM_W-1:0] mag;

	logic signed [ELEM_W-1:0] val_q;
	logic                     sat_q;
	logic                     zero_q;

	always_comb begin
		cabs = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
		dabs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
	end

	// numerator carries the half-divisor term for round-half-away
	always_ff @(posedge clk) begin
		if (en[0]) begin
			num_p <= (RW'(cabs) << (2 * FRAC_BITS + 1)) + RW'(dabs);
			d2_p  <= {dabs[DET_W-2:0], 1'b0};
			neg_p <= cof[COF_W-1] ^ det[DET_W-1];
			dz_p  <= (det == '0);
		end
	end

	// quotient of 2^ELEM_W or more saturates whatever the sign
	always_ff @(posedge clk) begin
		if (en[1]) begin
			rem_s[0] <= num_p;
			d2_s[0]  <= d2_p;
			q_s[0]   <= '0;
			neg_s[0] <= neg_p;
			dz_s[0]  <= dz_p;
			sat_s[0] <= (num_p >= (RW'(d2_p) << ELEM_W));
		end
	end

	for (genvar j = 0; j < ELEM_W; j++) begin : g_bit
		localparam int B = ELEM_W - 1 - j;
		logic [RW-1:0] trial;
		logic          ge;

		assign trial = RW'(d2_s[j]) << B;
		assign ge    = (rem_s[j] >= trial);

		always_ff @(posedge clk) begin
			if (en[j+2]) begin
				rem_s[j+1] <= ge ? (rem_s[j] - trial) : rem_s[j];
				d2_s[j+1]  <= d2_s[j];
				q_s[j+1]   <= q_s[j] | (ELEM_W'(ge) << B);
				neg_s[j+1] <= neg_s[j];
				dz_s[j+1]  <= dz_s[j];
				sat_s[j+1] <= sat_s[j];
			end
		end
	end

	always_comb begin
		lim = neg_s[ELEM_W] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
		big = sat_s[ELEM_W] || (q_s[ELEM_W] > lim);
		mag = big ? lim : q_s[ELEM_W];
	end

	always_ff @(posedge clk) begin
		if (en[ELEM_W+2]) begin
			val_q  <= dz_s[ELEM_W] ? '0
				: (neg_s[ELEM_W] ? $signed(ELEM_W'(-mag)) : $signed(mag));
			sat_q  <= !dz_s[ELEM_W] && big;
			zero_q <= dz_s[ELEM_W];
		end
	end

	assign val  = val_q;
	assign sat  = sat_q;
	assign zero = zero_q;

endmodule

FILE: sv/matrix3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Inverse of a signed fixed-point 3x3 matrix by adjugate and determinant.
// ----------------------------------------------------------------------------
// Accepts one matrix per cycle while the input is not stalled and returns
// its rounded, saturated inverse. The nine divider lanes resolve one
// quotient bit per stage. Stalls fill bubbles first; the input stalls only
// when every stage is full and the output is held. A zero determinant gives
// all-zero elements with singular set; a quotient outside the element range
// saturates and sets overflow.
`include "assert_macros.svh"

module matrix3_inverse_core #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  m3i_pkg::req_t   req,
	output logic            res_valid,
	input  logic            res_stall,
	output m3i_pkg::rsp_t   res
);
	import m3i_pkg::*;

	localparam int S = PIPE_DEPTH;

	logic [S:1] v_q;
	logic [S:1] en;

	logic signed [ELEM_W-1:0] m      [9];
	logic signed [ELEM_W-1:0] r0_s1  [3];
	logic signed [ELEM_W-1:0] r0_s2  [3];
	logic signed [COF_W-1:0]  cof    [9];
	logic signed [COF_W-1:0]  cof_s3 [9];
	logic signed [COF_W-1:0]  cof_s4 [9];
	logic signed [COF_W-1:0]  dcof   [3];
	logic signed [DET_W-1:0]  det;
	logic signed [ELEM_W-1:0] val    [9];
	logic [8:0]               sat;
	logic [8:0]               zero;

	// a stage advances when the output is not stalled, or when it or some stage downstream is empty
	for (genvar k = 1; k <= S; k++) begin : g_ctl
		assign en[k] = !res_stall || !(&v_q[S:k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en[k]) begin
				v_q[k] <= (k == 1) ? req_valid : v_q[(k == 1) ? 1 : k-1];
			end
		end
	end

	assign req_stall = !en[1];
	assign res_valid = v_q[S];

	assign m[0] = req.a00;
	assign m[1] = req.a01;
	assign m[2] = req.a02;
	assign m[3] = req.a10;
	assign m[4] = req.a11;
	assign m[5] = req.a12;
	assign m[6] = req.a20;
	assign m[7] = req.a21;
	assign m[8] = req.a22;

	for (genvar k = 0; k < 9; k++) begin : g_cof
		m3i_cof_lane u_cof (
			.clk (clk),
			.en  (en[2:1]),
			.x0  (m[COF_SEL[k][0]]),
			.x1  (m[COF_SEL[k][1]]),
			.y0  (m[COF_SEL[k][2]]),
			.y1  (m[COF_SEL[k][3]]),
			.cof (cof[k])
		);
	end

	// hold row 0 and the cofactors alongside the determinant stages
	always_ff @(posedge clk) begin
		if (en[1]) r0_s1 <= m[0:2];
		if (en[2]) r0_s2 <= r0_s1;
		if (en[3]) cof_s3 <= cof;
		if (en[4]) cof_s4 <= cof_s3;
	end

	assign dcof[0] = cof[0];
	assign dcof[1] = cof[3];
	assign dcof[2] = cof[6];

	m3i_det u_det (
		.clk  (clk),
		.en   (en[4:3]),
		.row0 (r0_s2),
		.cof  (dcof),
		.det  (det)
	);

	for (genvar k = 0; k < 9; k++) begin : g_div
		m3i_div_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_div (
			.clk  (clk),
			.en   (en[S:5]),
			.cof  (cof_s4[k]),
			.det  (det),
			.val  (val[k]),
			.sat  (sat[k]),
			.zero (zero[k])
		);
	end

	// merge the lanes into one response
	always_comb begin
		res.inv00    = val[0];
		res.inv01    = val[1];
		res.inv02    = val[2];
		res.inv10    = val[3];
		res.inv11    = val[4];
		res.inv12    = val[5];
		res.inv20    = val[6];
		res.inv21    = val[7];
		res.inv22    = val[8];
		res.singular = &zero;
		res.overflow = |sat;
	end

	`CHK_SAME(a_sing_clean, res_valid && res.singular, !res.overflow && res.inv00 == '0 && res.inv22 == '0, "singular response not cleared")
	`CHK_SAME(a_flow_open, !res_stall, !req_stall, "request stalled while output drains")
	`CHK_SAME(a_out_empty, !res_valid, !req_stall, "request stalled with empty output stage")

endmodule

FILE: tb/tb_matrix3_inverse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3_inverse_core
// Self-checking bench for the pipelined 3x3 fixed-point inverse.
// ----------------------------------------------------------------------------
// A directed table (identity, scaled diagonals, singular and saturating
// matrices, extreme elements) runs first, then random matrices of several
// shapes. Every accepted request is predicted in wide integer arithmetic and
// queued; results are compared field by field in order. Both sides idle at
// random.
module tb_matrix3_inverse_core;
	import m3i_pkg::*;

	localparam int FB       = FRAC_BITS_DEF;
	localparam int N_RANDOM = 1400;
	localparam int LIMIT    = 2000000;
	localparam logic signed [ELEM_W-1:0] ONE  = 32'sh0001_0000;
	localparam logic signed [ELEM_W-1:0] EMAX = 32'sh7fff_ffff;
	localparam logic signed [ELEM_W-1:0] EMIN = 32'sh8000_0000;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		req_t m;
		logic has_exp;
		rsp_t exp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	rsp_t res;

	rsp_t inverse_q[$];
	int errors = 0;
	int n_checked = 0;
	int n_singular = 0;
	int n_sat = 0;
	int cycles = 0;
	row_t dir_tab[$];

	matrix3_inverse_core uut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always #6 clk = ~clk;

	// round(c * 2^2F / d) away from zero on ties, saturated to the element range
	function automatic logic signed [ELEM_W-1:0] div_round(wide_t c, wide_t d,
			ref logic sat);
		wide_t n, da, q, lim;
		logic neg;
		neg = (c < 0) != (d < 0);
		n = (c < 0) ? -c : c;
		da = (d < 0) ? -d : d;
		q = ((n <<< (2 * FB + 1)) + da) / (da <<< 1);
		lim = neg ? (wide_t'(1) <<< (ELEM_W - 1)) : ((wide_t'(1) <<< (ELEM_W - 1)) - 1);
		if (q > lim) begin
			q = lim;
			sat = 1'b1;
		end
		if (neg)
			q = -q;
		return q[ELEM_W-1:0];
	endfunction

	function automatic rsp_t invert3(req_t m);
		wide_t a[9];
		wide_t det, cof;
		logic sat;
		logic signed [ELEM_W-1:0] el[9];
		rsp_t r;
		a[0] = m.a00; a[1] = m.a01; a[2] = m.a02;
		a[3] = m.a10; a[4] = m.a11; a[5] = m.a12;
		a[6] = m.a20; a[7] = m.a21; a[8] = m.a22;
		det = a[0]*a[4]*a[8] + a[1]*a[5]*a[6] + a[2]*a[3]*a[7]
			- a[0]*a[5]*a[7] - a[1]*a[3]*a[8] - a[2]*a[4]*a[6];
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		sat = 1'b0;
		// adjugate entry (i,j) is the cofactor of (j,i)
		cof = a[4]*a[8] - a[7]*a[5]; el[0] = div_round(cof, det, sat);
		cof = a[7]*a[2] - a[1]*a[8]; el[1] = div_round(cof, det, sat);
		cof = a[1]*a[5] - a[4]*a[2]; el[2] = div_round(cof, det, sat);
		cof = a[6]*a[5] - a[3]*a[8]; el[3] = div_round(cof, det, sat);
		cof = a[0]*a[8] - a[6]*a[2]; el[4] = div_round(cof, det, sat);
		cof = a[3]*a[2] - a[0]*a[5]; el[5] = div_round(cof, det, sat);
		cof = a[3]*a[7] - a[6]*a[4]; el[6] = div_round(cof, det, sat);
		cof = a[6]*a[1] - a[0]*a[7]; el[7] = div_round(cof, det, sat);
		cof = a[0]*a[4] - a[3]*a[1]; el[8] = div_round(cof, det, sat);
		r.inv00 = el[0]; r.inv01 = el[1]; r.inv02 = el[2];
		r.inv10 = el[3]; r.inv11 = el[4]; r.inv12 = el[5];
		r.inv20 = el[6]; r.inv21 = el[7]; r.inv22 = el[8];
		r.overflow = sat;
		return r;
	endfunction

	function automatic req_t diag3(logic signed [ELEM_W-1:0] x, y, z);
		req_t m;
		m = '0;
		m.a00 = x; m.a11 = y; m.a22 = z;
		return m;
	endfunction

	function automatic rsp_t inv_diag(logic signed [ELEM_W-1:0] x, y, z, logic ov);
		rsp_t r;
		r = '0;
		r.inv00 = x; r.inv11 = y; r.inv22 = z; r.overflow = ov;
		return r;
	endfunction

	function automatic logic signed [ELEM_W-1:0] rnd_elem(int shape);
		unique case (shape)
			0: return $urandom();
			1: return $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
			2: return $signed($urandom_range(0, 512)) - 256;
			default: begin
				unique case ($urandom_range(0, 5))
					0: return EMAX;
					1: return EMIN;
					2: return 0;
					3: return ONE;
					4: return -ONE;
					default: return $urandom_range(0, 3) - 1;
				endcase
			end
		endcase
	endfunction

	function automatic req_t rnd_matrix();
		req_t m;
		int shape;
		shape = $urandom_range(0, 3);
		m.a00 = rnd_elem(shape); m.a01 = rnd_elem(shape); m.a02 = rnd_elem(shape);
		m.a10 = rnd_elem(shape); m.a11 = rnd_elem(shape); m.a12 = rnd_elem(shape);
		m.a20 = rnd_elem(shape); m.a21 = rnd_elem(shape); m.a22 = rnd_elem(shape);
		// make some rows dependent to hit singular matrices
		if ($urandom_range(0, 9) == 0) begin
			m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
		end
		return m;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 3) != 0)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	task automatic push_row(req_t m, logic has_exp, rsp_t exp);
		row_t r;
		r.m = m; r.has_exp = has_exp; r.exp = exp;
		dir_tab.push_back(r);
	endtask

	// hold the request until accepted, then queue its prediction
	task automatic send(req_t m, logic has_exp, rsp_t exp);
		rsp_t p;
		p = invert3(m);
		if (has_exp && p !== exp) begin
			$display("%0t table entry disagrees with prediction: exp %h got %h",
				$realtime, exp, p);
			errors++;
		end
		req_valid <= 1'b1;
		req <= m;
		do @(posedge clk); while (req_stall);
		inverse_q.push_back(p);
		if (p.singular) n_singular++;
		if (p.overflow) n_sat++;
	endtask

	task automatic idle_req(int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			req <= '0;
			repeat (n) @(posedge clk);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (inverse_q.size() == 0) begin
				$display("%0t unexpected result %h", $realtime, res);
				errors++;
			end else begin
				e = inverse_q.pop_front();
				n_checked++;
				if (res.inv00 !== e.inv00) begin
					$display("%0t inv00 exp %h got %h", $realtime, e.inv00, res.inv00); errors++;
				end
				if (res.inv01 !== e.inv01) begin
					$display("%0t inv01 exp %h got %h", $realtime, e.inv01, res.inv01); errors++;
				end
				if (res.inv02 !== e.inv02) begin
					$display("%0t inv02 exp %h got %h", $realtime, e.inv02, res.inv02); errors++;
				end
				if (res.inv10 !== e.inv10) begin
					$display("%0t inv10 exp %h got %h", $realtime, e.inv10, res.inv10); errors++;
				end
				if (res.inv11 !== e.inv11) begin
					$display("%0t inv11 exp %h got %h", $realtime, e.inv11, res.inv11); errors++;
				end
				if (res.inv12 !== e.inv12) begin
					$display("%0t inv12 exp %h got %h", $realtime, e.inv12, res.inv12); errors++;
				end
				if (res.inv20 !== e.inv20) begin
					$display("%0t inv20 exp %h got %h", $realtime, e.inv20, res.inv20); errors++;
				end
				if (res.inv21 !== e.inv21) begin
					$display("%0t inv21 exp %h got %h", $realtime, e.inv21, res.inv21); errors++;
				end
				if (res.inv22 !== e.inv22) begin
					$display("%0t inv22 exp %h got %h", $realtime, e.inv22, res.inv22); errors++;
				end
				if (res.singular !== e.singular) begin
					$display("%0t singular exp %b got %b", $realtime, e.singular,
						res.singular); errors++;
				end
				if (res.overflow !== e.overflow) begin
					$display("%0t overflow exp %b got %b", $realtime, e.overflow,
						res.overflow); errors++;
				end
			end
		end
	end

	// receiver stalls: mostly short, a few long, with quiet stretches
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 3) == 0) begin
				n = gap_len();
				res_stall <= (n > 0);
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				inverse_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		rsp_t none;
		req_t m;
		none = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_row(diag3(ONE, ONE, ONE), 1'b1, inv_diag(ONE, ONE, ONE, 1'b0));
		push_row(diag3(2 * ONE, -ONE, ONE / 2), 1'b1,
			inv_diag(ONE / 2, -ONE, 2 * ONE, 1'b0));
		push_row('0, 1'b1, rsp_t'({{(9 * ELEM_W){1'b0}}, 1'b1, 1'b0}));
		// tiny diagonal: 1/2^-16 = 2^16 saturates
		push_row(diag3(1, 1, 1), 1'b1, inv_diag(EMAX, EMAX, EMAX, 1'b1));
		push_row(diag3(-1, ONE, ONE), 1'b1, inv_diag(EMIN, ONE, ONE, 1'b1));
		push_row(diag3(EMAX, EMAX, EMAX), 1'b0, none);
		push_row(diag3(EMIN, EMIN, EMIN), 1'b0, none);
		push_row(diag3(EMIN, EMAX, -ONE), 1'b0, none);
		push_row(req_t'({9{EMAX}}), 1'b0, none);
		push_row(req_t'({9{EMIN}}), 1'b0, none);
		push_row(req_t'({9{32'hffff_ffff}}), 1'b0, none);
		// rounding cases: inverses of 3 and 5 in Q16.16; odd denominators give no ties
		push_row(diag3(3 * ONE, 3, ONE), 1'b0, none);
		push_row(diag3(3, -3, 5), 1'b0, none);
		m = '0;
		m.a00 = ONE; m.a01 = 2 * ONE; m.a02 = 3 * ONE;
		m.a10 = 0; m.a11 = ONE; m.a12 = 4 * ONE;
		m.a20 = 5 * ONE; m.a21 = 6 * ONE; m.a22 = 0;
		push_row(m, 1'b0, none);
		m.a20 = 2 * ONE; m.a21 = 4 * ONE; m.a22 = 6 * ONE; // dependent rows
		push_row(m, 1'b1, rsp_t'({{(9 * ELEM_W){1'b0}}, 1'b1, 1'b0}));
		push_row(req_t'({32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
			32'h1234_5678, 32'h8765_4321, 32'h0f0f_f0f0}), 1'b0, none);
		push_row(req_t'({32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
			32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'hedcb_a987, 32'h789a_bcde, 32'hf0f0_0f0f}), 1'b0, none);

		foreach (dir_tab[i])
			send(dir_tab[i].m, dir_tab[i].has_exp, dir_tab[i].exp);
		req_valid <= 1'b0;

		// drain fully before the random part
		while (inverse_q.size() != 0) @(posedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				req_valid <= 1'b0;
				while (inverse_q.size() != 0) @(posedge clk);
			end
			if ((i / 200) % 2 == 1)
				idle_req(gap_len());
			send(rnd_matrix(), 1'b0, none);
		end
		req_valid <= 1'b0;

		while (inverse_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);

		$display("checked %0d inverses (%0d singular, %0d saturated)", n_checked,
			n_singular, n_sat);
		$display("directed table of %0d rows plus %0d random matrices", dir_tab.size(),
			N_RANDOM);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
